>>> hdl/sid_pkg.sv
// sid_pkg: widths, constants and bundle types for the symmetric 3x3 inverse
// pipeline; used by the top level, the divider step and the checker
package sid_pkg;

   // entry format
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // derived widths of the exact intermediate values
   localparam int MW    = DATA_WIDTH + 1;           // diagonal sum
   localparam int CW    = 2 * MW + 1;               // cofactor
   localparam int LO_W  = (CW + 1) / 2;             // low cofactor slice
   localparam int HI_W  = CW - LO_W;                // high cofactor slice
   localparam int PW    = MW + CW;                  // determinant term
   localparam int DETW  = PW + 2;                   // determinant
   localparam int NUMW  = CW + 2 * FRAC_BITS;       // scaled cofactor
   localparam int QB    = DATA_WIDTH;               // quotient bits
   localparam int CMPW  = DETW + QB;                // overflow compare
   localparam int LANES = 6;
   localparam int NPROD = 2 * LANES;
   localparam int NDET  = 3;

   // pipeline depth: eight front stages, one per quotient bit, one output
   localparam int FRONT = 8;
   localparam int NSTG  = FRONT + QB + 1;

   // one division lane
   typedef struct packed {
      logic [DETW-1:0] rem;
      logic [QB-1:0]   low;
      logic [QB-1:0]   quo;
      logic            ovf;
      logic            neg;
   } lane_type;

   // all lanes share the determinant magnitude
   typedef struct packed {
      logic [DETW-1:0]             den;
      logic                        zero;
      lane_type [LANES-1:0]        lane;
   } div_type;

endpackage

>>> hdl/sid_div_step.sv
// sid_div_step: one restoring division step for all six lanes, registered
// depends on sid_pkg
module sid_div_step (
   input  logic             clock,
   input  logic             en,
   input  sid_pkg::div_type d_in,
   output sid_pkg::div_type d_ff
);

   sid_pkg::div_type d_in_next;

   // compare shifted remainder with the divisor, subtract when it fits
   always_comb begin
      logic [sid_pkg::DETW:0] t;
      logic                   fit;
      d_in_next = d_in;
      for (int k = 0; k < sid_pkg::LANES; k++) begin
         t   = {d_in.lane[k].rem, d_in.lane[k].low[sid_pkg::QB-1]};
         fit = (t >= {1'b0, d_in.den});
         if (fit) begin
            d_in_next.lane[k].rem = sid_pkg::DETW'(t - {1'b0, d_in.den});
         end else begin
            d_in_next.lane[k].rem = t[sid_pkg::DETW-1:0];
         end
         d_in_next.lane[k].quo = {d_in.lane[k].quo[sid_pkg::QB-2:0], fit};
         d_in_next.lane[k].low = {d_in.lane[k].low[sid_pkg::QB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end

endmodule

>>> hdl/sym3x3_inverse_diag_offset.sv
// sym3x3_inverse_diag_offset: inverse of a symmetric 3x3 matrix plus a
// diagonal offset, signed fixed point; depends on sid_pkg and sid_div_step
//
// Usage: one beat on the req_ channel carries the six upper-triangle entries
// and three diagonal offsets. One beat on the rsp_ channel returns the six
// unique entries of the inverse, rounded toward zero and clipped, with the
// singular flag (zero determinant, entries zero) and the saturated flag.
// There are 41 register stages: eight stages form the diagonal sums, the
// twelve cofactor products, the cofactors, the split determinant products,
// their recombination, the determinant, the magnitudes and the overflow test;
// then one stage per quotient bit of the restoring divider (32 stages,
// six lanes sharing one divisor) and a final clip and sign stage.
// Throughput is one beat per cycle while the receiver keeps taking beats. The pipeline advances as a whole
// whenever the output register is empty or being taken, so req_ready
// follows rsp_ready while the output holds a beat; a stalled receiver
// freezes every stage, and nothing is lost or repeated.
// A synchronous reset clears the valid bits; data registers are not reset.
module sym3x3_inverse_diag_offset (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_11,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_12,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_13,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_22,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_23,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_33,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_diag_add_1,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_diag_add_2,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_diag_add_3,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_11,
   output logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_12,
   output logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_13,
   output logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_22,
   output logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_23,
   output logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_33,
   output logic                                   rsp_singular,
   output logic                                   rsp_saturated
);

   localparam int MW    = sid_pkg::MW;
   localparam int CW    = sid_pkg::CW;
   localparam int LO_W  = sid_pkg::LO_W;
   localparam int HI_W  = sid_pkg::HI_W;
   localparam int PW    = sid_pkg::PW;
   localparam int DETW  = sid_pkg::DETW;
   localparam int NUMW  = sid_pkg::NUMW;
   localparam int QB    = sid_pkg::QB;
   localparam int CMPW  = sid_pkg::CMPW;
   localparam int LANES = sid_pkg::LANES;
   localparam int NPROD = sid_pkg::NPROD;
   localparam int NDET  = sid_pkg::NDET;
   localparam int NSTG  = sid_pkg::NSTG;
   localparam int DW    = sid_pkg::DATA_WIDTH;
   localparam int F2    = 2 * sid_pkg::FRAC_BITS;

   logic en;

   // valid chain
   logic [NSTG-1:0] vld_ff, vld_in;

   assign en        = !vld_ff[NSTG-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NSTG-1];
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: diagonal sums and off-diagonal entries
   logic signed [MW-1:0] m11_ff, m22_ff, m33_ff, b0_ff, c0_ff, e0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m11_ff <= MW'(req_a_11) + MW'(req_diag_add_1);
         m22_ff <= MW'(req_a_22) + MW'(req_diag_add_2);
         m33_ff <= MW'(req_a_33) + MW'(req_diag_add_3);
         b0_ff  <= MW'(req_a_12);
         c0_ff  <= MW'(req_a_13);
         e0_ff  <= MW'(req_a_23);
      end
   end

   // stage 1: the twelve cofactor products, in minuend/subtrahend pairs
   logic signed [MW-1:0]   opa [NPROD];
   logic signed [MW-1:0]   opb [NPROD];
   logic signed [2*MW-1:0] pp_ff [NPROD];
   logic signed [MW-1:0]   m11_1_ff, b1_ff, c1_ff;

   always_comb begin
      opa[0]  = m22_ff; opb[0]  = m33_ff;
      opa[1]  = e0_ff;  opb[1]  = e0_ff;
      opa[2]  = c0_ff;  opb[2]  = e0_ff;
      opa[3]  = b0_ff;  opb[3]  = m33_ff;
      opa[4]  = b0_ff;  opb[4]  = e0_ff;
      opa[5]  = c0_ff;  opb[5]  = m22_ff;
      opa[6]  = m11_ff; opb[6]  = m33_ff;
      opa[7]  = c0_ff;  opb[7]  = c0_ff;
      opa[8]  = b0_ff;  opb[8]  = c0_ff;
      opa[9]  = m11_ff; opb[9]  = e0_ff;
      opa[10] = m11_ff; opb[10] = m22_ff;
      opa[11] = b0_ff;  opb[11] = b0_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NPROD; i++) begin
            pp_ff[i] <= opa[i] * opb[i];
         end
         m11_1_ff <= m11_ff;
         b1_ff    <= b0_ff;
         c1_ff    <= c0_ff;
      end
   end

   // stage 2: cofactors
   logic signed [CW-1:0] cof2_ff [LANES];
   logic signed [MW-1:0] m11_2_ff, b2_ff, c2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            cof2_ff[i] <= CW'(pp_ff[2*i]) - CW'(pp_ff[2*i+1]);
         end
         m11_2_ff <= m11_1_ff;
         b2_ff    <= b1_ff;
         c2_ff    <= c1_ff;
      end
   end

   // stage 3: determinant terms as two partial products each
   logic signed [MW-1:0]        dx [NDET];
   logic signed [MW+LO_W:0]     plo_ff [NDET];
   logic signed [MW+HI_W-1:0]   phi_ff [NDET];
   logic signed [CW-1:0]        cof3_ff [LANES];

   always_comb begin
      dx[0] = m11_2_ff;
      dx[1] = b2_ff;
      dx[2] = c2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NDET; j++) begin
            plo_ff[j] <= dx[j] * $signed({1'b0, cof2_ff[j][LO_W-1:0]});
            phi_ff[j] <= dx[j] * $signed(cof2_ff[j][CW-1:LO_W]);
         end
         cof3_ff <= cof2_ff;
      end
   end

   // stage 4: recombine the partial products
   logic signed [PW-1:0] term_ff [NDET];
   logic signed [CW-1:0] cof4_ff [LANES];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NDET; j++) begin
            term_ff[j] <= (PW'(phi_ff[j]) <<< LO_W) + PW'(plo_ff[j]);
         end
         cof4_ff <= cof3_ff;
      end
   end

   // stage 5: determinant
   logic signed [DETW-1:0] det_ff;
   logic signed [CW-1:0]   cof5_ff [LANES];

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff  <= DETW'(term_ff[0]) + DETW'(term_ff[1]) + DETW'(term_ff[2]);
         cof5_ff <= cof4_ff;
      end
   end

   // stage 6: magnitudes and quotient signs
   logic [DETW-1:0] dabs_ff;
   logic            dzero_ff;
   logic [NUMW-1:0] nabs_ff [LANES];
   logic            neg_ff [LANES];

   always_ff @(posedge clock) begin
      logic [NUMW-1:0] num;
      if (en) begin
         dabs_ff  <= det_ff[DETW-1] ? DETW'(~det_ff + 1'b1) : det_ff;
         dzero_ff <= (det_ff == '0);
         for (int i = 0; i < LANES; i++) begin
            num        = {cof5_ff[i], {F2{1'b0}}};
            nabs_ff[i] <= cof5_ff[i][CW-1] ? NUMW'(~num + 1'b1) : num;
            neg_ff[i]  <= cof5_ff[i][CW-1] ^ det_ff[DETW-1];
         end
      end
   end

   // stage 7: overflow test and divider setup
   sid_pkg::div_type dstage [QB+1];
   sid_pkg::div_type div0_in;

   always_comb begin
      div0_in.den  = dabs_ff;
      div0_in.zero = dzero_ff;
      for (int i = 0; i < LANES; i++) begin
         div0_in.lane[i].ovf = (CMPW'(nabs_ff[i]) >= (CMPW'(dabs_ff) << QB));
         div0_in.lane[i].rem = DETW'(nabs_ff[i] >> QB);
         div0_in.lane[i].low = nabs_ff[i][QB-1:0];
         div0_in.lane[i].quo = '0;
         div0_in.lane[i].neg = neg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dstage[0] <= div0_in;
      end
   end

   // divider: one quotient bit per stage
   for (genvar g = 0; g < QB; g++) begin : g_div
      sid_div_step u_step (
         .clock (clock),
         .en    (en),
         .d_in  (dstage[g]),
         .d_ff  (dstage[g+1])
      );
   end

   // output stage: clip, apply sign, singular override
   localparam logic [QB-1:0] HALF = {1'b1, {(QB-1){1'b0}}};

   logic [DW-1:0]    res_in [LANES];
   logic [DW-1:0]    res_ff [LANES];
   logic [LANES-1:0] sat_in;
   logic             sing_ff, satf_ff;

   always_comb begin
      sid_pkg::lane_type ln;
      for (int i = 0; i < LANES; i++) begin
         ln = dstage[QB].lane[i];
         sat_in[i] = ln.ovf || (ln.neg ? (ln.quo > HALF) : ln.quo[QB-1]);
         if (dstage[QB].zero) begin
            res_in[i] = '0;
         end else if (sat_in[i]) begin
            res_in[i] = ln.neg ? HALF : ~HALF;
         end else begin
            res_in[i] = ln.neg ? DW'(~ln.quo + 1'b1) : ln.quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff  <= res_in;
         sing_ff <= dstage[QB].zero;
         satf_ff <= !dstage[QB].zero && (|sat_in);
      end
   end

   assign rsp_inv_11    = res_ff[0];
   assign rsp_inv_12    = res_ff[1];
   assign rsp_inv_13    = res_ff[2];
   assign rsp_inv_22    = res_ff[3];
   assign rsp_inv_23    = res_ff[4];
   assign rsp_inv_33    = res_ff[5];
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = satf_ff;

endmodule

>>> hdl/sid_check.sv
// sid_check: port-level assertions for sym3x3_inverse_diag_offset, bound
// to the top level; depends on sid_pkg
module sid_check (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [sid_pkg::DATA_WIDTH-1:0] rsp_inv_11,
   input logic signed [sid_pkg::DATA_WIDTH-1:0] rsp_inv_12,
   input logic signed [sid_pkg::DATA_WIDTH-1:0] rsp_inv_13,
   input logic signed [sid_pkg::DATA_WIDTH-1:0] rsp_inv_22,
   input logic signed [sid_pkg::DATA_WIDTH-1:0] rsp_inv_23,
   input logic signed [sid_pkg::DATA_WIDTH-1:0] rsp_inv_33,
   input logic                                  rsp_singular,
   input logic                                  rsp_saturated
);

   localparam logic [sid_pkg::DATA_WIDTH-1:0] MAXV = {1'b0, {(sid_pkg::DATA_WIDTH-1){1'b1}}};
   localparam logic [sid_pkg::DATA_WIDTH-1:0] MINV = {1'b1, {(sid_pkg::DATA_WIDTH-1){1'b0}}};

   // a stalled result beat holds its valid, inv_11, inv_33 and both flags
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inv_11) && $stable(rsp_inv_33)
         && $stable(rsp_singular) && $stable(rsp_saturated))
      else $error("result beat changed while stalled");

   // no result beat right after reset
   a_reset: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // input side is open whenever the output can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input blocked while pipeline can advance");

   // singular beats carry zero entries and no clip
   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated && rsp_inv_11 == '0 && rsp_inv_12 == '0
         && rsp_inv_13 == '0 && rsp_inv_22 == '0 && rsp_inv_23 == '0 && rsp_inv_33 == '0)
      else $error("singular beat with nonzero entries");

   // a clipped beat has at least one entry at a limit
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_inv_11 == MAXV || rsp_inv_11 == MINV || rsp_inv_12 == MAXV || rsp_inv_12 == MINV
         || rsp_inv_13 == MAXV || rsp_inv_13 == MINV || rsp_inv_22 == MAXV
         || rsp_inv_22 == MINV || rsp_inv_23 == MAXV || rsp_inv_23 == MINV
         || rsp_inv_33 == MAXV || rsp_inv_33 == MINV)
      else $error("saturated beat without a clipped entry");

endmodule

bind sym3x3_inverse_diag_offset sid_check u_sid_check (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_inv_11    (rsp_inv_11),
   .rsp_inv_12    (rsp_inv_12),
   .rsp_inv_13    (rsp_inv_13),
   .rsp_inv_22    (rsp_inv_22),
   .rsp_inv_23    (rsp_inv_23),
   .rsp_inv_33    (rsp_inv_33),
   .rsp_singular  (rsp_singular),
   .rsp_saturated (rsp_saturated)
);

>>> verif/sid_checker.sv
// sid_checker: watches the req_ and rsp_ channels of the symmetric 3x3 inverse,
// predicts every rsp_ beat and compares it field by field; depends on sid_pkg
module sid_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_11,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_12,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_13,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_22,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_23,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_a_33,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_diag_add_1,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_diag_add_2,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  req_diag_add_3,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_11,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_12,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_13,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_22,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_23,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0]  rsp_inv_33,
   input  logic                                   rsp_singular,
   input  logic                                   rsp_saturated,
   output int                                     errors,
   output int                                     pending,
   output int                                     singular_seen,
   output int                                     saturated_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [sid_pkg::DATA_WIDTH-1:0] entry_type;
   typedef logic [sid_pkg::DATA_WIDTH-1:0]        word_type;
   typedef logic signed [255:0]                   exact_type;

   // one predicted inverse
   typedef struct packed {
      entry_type [5:0] inv;
      logic            singular;
      logic            saturated;
   } inverse_type;

   inverse_type inverse_fifo[$];

   // exact cofactor / determinant, then truncating divide and clip
   function automatic inverse_type invert_matrix(entry_type a11, entry_type a12,
                                                 entry_type a13, entry_type a22,
                                                 entry_type a23, entry_type a33,
                                                 entry_type d1, entry_type d2,
                                                 entry_type d3);
      exact_type m11, m22, m33, b, c, e, det, num, quo;
      exact_type cof[6];
      exact_type hi_lim, lo_lim;
      inverse_type r;
      m11 = exact_type'(a11) + exact_type'(d1);
      m22 = exact_type'(a22) + exact_type'(d2);
      m33 = exact_type'(a33) + exact_type'(d3);
      b = exact_type'(a12);
      c = exact_type'(a13);
      e = exact_type'(a23);
      hi_lim = (exact_type'(1) <<< (sid_pkg::DATA_WIDTH - 1)) - 1;
      lo_lim = -(exact_type'(1) <<< (sid_pkg::DATA_WIDTH - 1));
      cof[0] = m22 * m33 - e * e;
      cof[1] = c * e - b * m33;
      cof[2] = b * e - c * m22;
      cof[3] = m11 * m33 - c * c;
      cof[4] = b * c - m11 * e;
      cof[5] = m11 * m22 - b * b;
      det = m11 * cof[0] + b * cof[1] + c * cof[2];
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      for (int i = 0; i < 6; i++) begin
         num = cof[i] <<< (2 * sid_pkg::FRAC_BITS);
         quo = num / det;
         if (quo > hi_lim) begin
            quo = hi_lim;
            r.saturated = 1'b1;
         end else if (quo < lo_lim) begin
            quo = lo_lim;
            r.saturated = 1'b1;
         end
         r.inv[i] = quo[sid_pkg::DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   task automatic check_field(string name, word_type want, word_type got);
      if (want !== got) begin
         errors++;
         $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      end
   endtask

   initial begin
      errors = 0;
      pending = 0;
      singular_seen = 0;
      saturated_seen = 0;
   end

   // predict on each req beat, compare on each rsp beat
   always @(posedge clock) begin
      inverse_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            inverse_fifo.push_back(invert_matrix(req_a_11, req_a_12, req_a_13, req_a_22,
                                                 req_a_23, req_a_33, req_diag_add_1,
                                                 req_diag_add_2, req_diag_add_3));
         if (rsp_valid && rsp_ready) begin
            if (inverse_fifo.size() == 0) begin
               errors++;
               $display("%0t mismatch: rsp beat with nothing expected", $time);
            end else begin
               want = inverse_fifo.pop_front();
               check_field("inv_11", want.inv[0], rsp_inv_11);
               check_field("inv_12", want.inv[1], rsp_inv_12);
               check_field("inv_13", want.inv[2], rsp_inv_13);
               check_field("inv_22", want.inv[3], rsp_inv_22);
               check_field("inv_23", want.inv[4], rsp_inv_23);
               check_field("inv_33", want.inv[5], rsp_inv_33);
               check_field("singular", word_type'(want.singular), word_type'(rsp_singular));
               check_field("saturated", word_type'(want.saturated),
                           word_type'(rsp_saturated));
               if (want.singular) singular_seen++;
               if (want.saturated) saturated_seen++;
            end
         end
      end
      pending = inverse_fifo.size();
   end

endmodule

>>> verif/testbench.sv
// testbench: drives directed and random matrices into the 3x3 symmetric inverse
// with random gaps and stalls; depends on sid_pkg, the block and sid_checker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 1880;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam logic signed [sid_pkg::DATA_WIDTH-1:0] ONE  = 1 <<< sid_pkg::FRAC_BITS;
   localparam logic signed [sid_pkg::DATA_WIDTH-1:0] MAXV =
      {1'b0, {(sid_pkg::DATA_WIDTH-1){1'b1}}};
   localparam logic signed [sid_pkg::DATA_WIDTH-1:0] MINV =
      {1'b1, {(sid_pkg::DATA_WIDTH-1){1'b0}}};

   typedef logic signed [sid_pkg::DATA_WIDTH-1:0] entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   entry_type req_a_11 = '0, req_a_12 = '0, req_a_13 = '0, req_a_22 = '0, req_a_23 = '0;
   entry_type req_a_33 = '0, req_diag_add_1 = '0, req_diag_add_2 = '0, req_diag_add_3 = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   entry_type rsp_inv_11, rsp_inv_12, rsp_inv_13, rsp_inv_22, rsp_inv_23, rsp_inv_33;
   logic rsp_singular, rsp_saturated;
   int errors, pending, singular_seen, saturated_seen;
   int cycles = 0, sent = 0, stall_left = 0;
   bit calm = 1'b0;

   always #2 clock = ~clock;

   sym3x3_inverse_diag_offset u_dut (.*);
   sid_checker u_checker (.*);

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver stalls, short mostly, sometimes long
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 99) < 25)
            stall_left <= gap_length() + 1;
      end
   end

   // one req beat, called at a rising edge; returns at the accepting edge, or after the idle gap that follows it
   task automatic send_matrix(entry_type a11, entry_type a12, entry_type a13,
                              entry_type a22, entry_type a23, entry_type a33,
                              entry_type d1, entry_type d2, entry_type d3);
      int gap;
      req_valid <= 1'b1;
      req_a_11 <= a11; req_a_12 <= a12; req_a_13 <= a13;
      req_a_22 <= a22; req_a_23 <= a23; req_a_33 <= a33;
      req_diag_add_1 <= d1; req_diag_add_2 <= d2; req_diag_add_3 <= d3;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sent++;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic entry_type near(int span);
      return entry_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic entry_type any_value();
      return entry_type'($urandom());
   endfunction

   initial begin
      int kind, waited;
      entry_type x, y, z;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_matrix(ONE, 0, 0, ONE, 0, ONE, 0, 0, 0);
      send_matrix(0, 0, 0, 0, 0, 0, ONE, ONE, ONE);
      send_matrix(2 * ONE, 0, 0, 4 * ONE, 0, 8 * ONE, 0, 0, 0);
      send_matrix(-ONE, 0, 0, -ONE, 0, -ONE, 0, 0, 0);
      send_matrix(4 * ONE, ONE, ONE / 2, 3 * ONE, -ONE, 5 * ONE, ONE, -ONE / 2, 2 * ONE);
      send_matrix(1, 0, 0, 1, 0, 1, 0, 0, 0);
      send_matrix(-1, 0, 0, -1, 0, -1, 0, 0, 0);
      send_matrix(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
      send_matrix(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
      send_matrix(MAXV, 0, 0, MAXV, 0, MAXV, MAXV, MAXV, MAXV);
      send_matrix(MINV, 0, 0, MINV, 0, MINV, MINV, MINV, MINV);
      send_matrix(MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV, MINV, MINV);
      send_matrix(3 * ONE, 0, 0, 2 * ONE, 0, ONE, -3 * ONE, 0, 0);
      send_matrix(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0);
      send_matrix(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 6 * ONE, 9 * ONE, 0, 0, 0);
      send_matrix(ONE, 0, 0, ONE, 0, ONE, MINV, MAXV, -ONE);
      send_matrix(2, 1, 1, 2, 1, 2, 0, 0, 0);
      send_matrix(ONE, ONE, 0, ONE, 0, ONE, 1, 0, 0);

      // random matrices, the first stretch without any idling
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         calm = (n < 150);
         if (n == RANDOM_BEATS / 2) begin
            req_valid <= 1'b0;
            // let the checker record the last accepted beat first
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            // well-conditioned, diagonally dominant
            send_matrix(entry_type'($urandom_range(4 * ONE, 64 * ONE)), near(ONE), near(ONE),
                        entry_type'($urandom_range(4 * ONE, 64 * ONE)), near(ONE),
                        entry_type'($urandom_range(4 * ONE, 64 * ONE)),
                        near(2 * ONE), near(2 * ONE), near(2 * ONE));
         end else if (kind < 65) begin
            send_matrix(near(4 * ONE), near(4 * ONE), near(4 * ONE), near(4 * ONE),
                        near(4 * ONE), near(4 * ONE), near(ONE), near(ONE), near(ONE));
         end else if (kind < 75) begin
            send_matrix(near(8), near(8), near(8), near(8), near(8), near(8),
                        near(4), near(4), near(4));
         end else if (kind < 90) begin
            send_matrix(any_value(), any_value(), any_value(), any_value(), any_value(),
                        any_value(), any_value(), any_value(), any_value());
         end else begin
            // two equal rows: singular, sometimes nudged by an offset
            x = near(16 * ONE);
            y = near(16 * ONE);
            z = near(16 * ONE);
            send_matrix(x, x, y, x, y, z, 0, ($urandom_range(0, 3) == 0) ? near(4) : 0, 0);
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // let the checker record the last accepted beat first
      @(posedge clock);
      waited = 0;
      while (pending != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);

      $display("sent %0d matrices: directed corners, random conditioned and raw values,",
               sent);
      $display("%0d singular and %0d saturating results checked", singular_seen,
               saturated_seen);
      if (errors == 0 && pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> sym3x3_inverse_diag_offset.f
hdl/sid_pkg.sv
hdl/sid_div_step.sv
hdl/sym3x3_inverse_diag_offset.sv
hdl/sid_check.sv
verif/sid_checker.sv
verif/testbench.sv
